FILE: rtl/core/tht_pkg.sv
// tht_pkg: shared types, constants and the toeplitz hash function
// for the hashed table block; depends on nothing
package tht_pkg;

  localparam int unsigned INDEX_BITS  = 10;
  localparam int unsigned TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int unsigned KEY_BITS    = 48;
  localparam int unsigned HASH_BITS   = 32;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [HASH_BITS-1:0]  word_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD
  } state_t;

  // secret key, bit 0 is the lsb of the last word listed
  localparam logic [319:0] SECRET_KEY = {
    32'h7C9C37DE, 32'h18DC4386, 32'hD9270F6F, 32'h260374B8, 32'hBFD0404B,
    32'h7872E224, 32'hDC1B91BB, 32'h011BA7A6, 32'h376CC87E, 32'hD6E31417
  };

  // 32-bit window of key bits off..off+31
  function automatic word_t key_window(input int unsigned off);
    return SECRET_KEY[off +: HASH_BITS];
  endfunction

  // toeplitz hash over ip bits 0..31 and port bits 32..47
  function automatic word_t flow_hash(input logic [31:0] ip, input logic [15:0] port);
    logic [KEY_BITS-1:0] key;
    word_t               h;
    key = {port, ip};
    h   = '0;
    for (int unsigned i = 0; i < KEY_BITS; i++) begin
      h = h ^ (key_window(i) & {HASH_BITS{key[i]}});
    end
    return h;
  endfunction

endpackage

FILE: rtl/core/tht_if.sv
// tht_if: valid/ready channel interfaces for request and result beats
// depends on tht_pkg
interface tht_in_if import tht_pkg::*; ();
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [31:0] ip_address;
  logic [15:0] port_number;
  logic [31:0] write_value;

  modport source (output valid, opcode, ip_address, port_number, write_value,
                  input ready);
  modport sink   (input valid, opcode, ip_address, port_number, write_value,
                  output ready);
endinterface

interface tht_out_if import tht_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t hash_value;
  word_t entry_value;

  modport source (output valid, hash_value, entry_value, input ready);
  modport sink   (input valid, hash_value, entry_value, output ready);
endinterface

FILE: rtl/core/toeplitz_hashed_table.sv
// toeplitz_hashed_table: toeplitz flow hash with table lookup and insert
// depends on tht_pkg and the channel interfaces in tht_if
//
//  channel   dir  beat                                          handshake
//  in_ch     in   opcode, ip_address, port_number, write_value  valid/ready
//  out_ch    out  hash_value, entry_value (lookups only)        valid/ready
//
// an insert goes through two steps (hash and register, memory write), a lookup
// through three (hash, memory read, load output register); the table read
// data is registered.
// after reset a clearing pass writes zero to all 2^INDEX_BITS entries
// before the first beat is taken.
// a finished result waits in the output register while the next beat is
// taken; a lookup holds in its load step while that register is still full.
module toeplitz_hashed_table import tht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tht_in_if.sink    in_ch,
  tht_out_if.source out_ch
);

  // table storage
  word_t mem [TABLE_DEPTH];

  state_t  state_r, state_nxt;
  idx_t    clr_cnt_r, clr_cnt_nxt;
  word_t   hash_r;
  opcode_t op_r;
  word_t   wval_r;
  word_t   rd_data_r;
  logic    out_valid_r, out_valid_nxt;
  word_t   out_hash_r;
  word_t   out_entry_r;

  logic    in_ready;
  logic    accept;
  logic    mem_wr_en;
  idx_t    mem_wr_addr;
  word_t   mem_wr_data;
  logic    mem_rd_en;
  logic    out_load;
  logic    out_free;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == idx_t'(TABLE_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_ACCESS;
      ST_ACCESS: state_nxt = (op_r == OP_INSERT) ? ST_IDLE : ST_LOAD;
      ST_LOAD:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = hash_r[INDEX_BITS-1:0];
    mem_wr_data = wval_r;
    mem_rd_en   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ACCESS: begin
        mem_wr_en = (op_r == OP_INSERT);
        mem_rd_en = (op_r == OP_LOOKUP);
      end
      ST_LOAD: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // clear counter and output valid
  always_comb begin
    clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + idx_t'(1) : clr_cnt_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the hashed request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      hash_r <= flow_hash(in_ch.ip_address, in_ch.port_number);
      op_r   <= in_ch.opcode;
      wval_r <= in_ch.write_value;
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  // table read port, registered data
  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= mem[hash_r[INDEX_BITS-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hash_r  <= hash_r;
      out_entry_r <= rd_data_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hash_value  = out_hash_r;
  assign out_ch.entry_value = out_entry_r;

endmodule

FILE: sim/testbench.sv
// testbench for toeplitz_hashed_table: directed and random lookup/insert beats,
// checked against a local toeplitz hash and table predictor
// depends on tht_pkg, tht_if and the toeplitz_hashed_table rtl
module testbench;
  import tht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned DRAIN_TAIL     = 16;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned POOL_SIZE      = 16;

  // secret key words, word 0 holds key bits 0..31
  localparam logic [9:0][31:0] SECRET_WORDS = {
    32'h7C9C37DE, 32'h18DC4386, 32'hD9270F6F, 32'h260374B8, 32'hBFD0404B,
    32'h7872E224, 32'hDC1B91BB, 32'h011BA7A6, 32'h376CC87E, 32'hD6E31417
  };

  typedef struct packed {
    opcode_t     op;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] entry_value;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  tht_in_if  in_ch ();
  tht_out_if out_ch ();

  toeplitz_hashed_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t       pending_requests[$];
  lookup_result_t expected_lookups[$];
  logic [31:0]    entry_model [TABLE_DEPTH];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_requests;
  int          holds_served;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int          errors;

  logic [31:0] pool_ip   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [31:0] collide_ip;

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // secret bits off..off+31
  function automatic logic [31:0] secret_window(input int unsigned off);
    int unsigned w;
    int unsigned s;
    w = off / 32;
    s = off % 32;
    if (s == 0) return SECRET_WORDS[w];
    return (SECRET_WORDS[w] >> s) | (SECRET_WORDS[w + 1] << (32 - s));
  endfunction

  // toeplitz hash of one flow key
  function automatic logic [31:0] flow_key_hash(input logic [31:0] ip,
                                                input logic [15:0] port);
    logic [31:0] h;
    h = '0;
    for (int unsigned i = 0; i < 32; i++) begin
      if (ip[i]) h = h ^ secret_window(i);
    end
    for (int unsigned i = 0; i < 16; i++) begin
      if (port[i]) h = h ^ secret_window(i + 32);
    end
    return h;
  endfunction

  // driver: offer pending beats, predict on every accepted one
  always @(posedge clk) begin : drive_requests
    logic [31:0] h;
    request_t    next_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        h = flow_key_hash(in_ch.ip_address, in_ch.port_number);
        if (in_ch.opcode == OP_INSERT) begin
          entry_model[h[INDEX_BITS-1:0]] = in_ch.write_value;
        end else begin
          expected_lookups.push_back('{hash_value: h,
                                       entry_value: entry_model[h[INDEX_BITS-1:0]]});
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.opcode      <= next_req.op;
          in_ch.ip_address  <= next_req.ip;
          in_ch.port_number <= next_req.port;
          in_ch.write_value <= next_req.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: drive ready, compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result beat: hash %h entry %h", $time,
                   out_ch.hash_value, out_ch.entry_value);
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_ch.hash_value !== want.hash_value) begin
            $display("%0t: hash_value mismatch: expected %h actual %h", $time,
                     want.hash_value, out_ch.hash_value);
            errors++;
          end
          if (out_ch.entry_value !== want.entry_value) begin
            $display("%0t: entry_value mismatch: expected %h actual %h", $time,
                     want.entry_value, out_ch.entry_value);
            errors++;
          end
        end
      end
      // long hold-off, otherwise random stalls
      if (hold_requests != holds_served) begin
        holds_served <= hold_requests;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[toeplitz_hashed_table] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_request(input opcode_t op, input logic [31:0] ip,
                               input logic [15:0] port, input logic [31:0] value);
    pending_requests.push_back('{op: op, ip: ip, port: port, value: value});
  endtask

  // block until every beat is sent and every lookup has returned
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_ch.valid || expected_lookups.size() != 0)
      @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // random beats, mostly on a small pool of keys so entries get reused
  task automatic random_phase(input int count, input int send_pct, input int recv_pct);
    int          k;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] value;
    opcode_t     op;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < 60) begin
        ip   = pool_ip[k];
        port = pool_port[k];
      end else begin
        ip   = $urandom;
        port = 16'($urandom);
      end
      op = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      queue_request(op, ip, port, value);
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_LOOKUP;
    in_ch.ip_address  = '0;
    in_ch.port_number = '0;
    in_ch.write_value = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_requests     = 0;
    holds_served      = 0;
    hold_left         = 0;
    idle_cycles       = 0;
    errors            = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) entry_model[i] = '0;

    // an address-only key difference that maps to the same table index
    collide_ip = 32'd1;
    while (flow_key_hash(collide_ip, 16'h0000) % TABLE_DEPTH != 0)
      collide_ip = collide_ip + 1;

    // key pool: random, upper half colliding with lower; keys 0, 1 all 0s, 1s
    for (int i = 0; i < POOL_SIZE / 2; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom);
      pool_ip[i + POOL_SIZE / 2]   = pool_ip[i] ^ collide_ip;
      pool_port[i + POOL_SIZE / 2] = pool_port[i];
    end
    pool_ip[0]   = '0;
    pool_port[0] = '0;
    pool_ip[1]   = '1;
    pool_port[1] = '1;

    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: never-written entries read as zero, field extremes
    queue_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_request(OP_LOOKUP, 32'h0000_0001, 16'h0000, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'h8000_0000, 16'h0000, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'h0000_0000, 16'h0001, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'h0000_0000, 16'h8000, 32'h0000_0000);
    // insert then lookup back to back on the same entry
    queue_request(OP_INSERT, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    queue_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hA5A5_5A5A);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
    // colliding keys share one entry, last insert wins
    queue_request(OP_INSERT, 32'h1234_5678, 16'hBEEF, 32'h1111_1111);
    queue_request(OP_INSERT, 32'h1234_5678 ^ collide_ip, 16'hBEEF, 32'h2222_2222);
    queue_request(OP_LOOKUP, 32'h1234_5678, 16'hBEEF, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'h1234_5678 ^ collide_ip, 16'hBEEF, 32'h0000_0000);
    // overwrite with zero
    queue_request(OP_INSERT, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    wait_drained();

    // random phases with different idle and stall mixes
    random_phase(90, 0, 0);
    random_phase(90, 70, 0);
    random_phase(90, 0, 70);
    random_phase(90, 35, 35);

    // long receiver hold-off while the sender keeps offering
    hold_requests = hold_requests + 1;
    random_phase(50, 0, 0);

    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("[toeplitz_hashed_table] OK");
    end else begin
      $display("[toeplitz_hashed_table] ERROR");
    end
    $finish;
  end

endmodule
